// ----- rtl/core/breakpoint_watchpoint_table_defines.svh -----
// Assertion macros for the breakpoint and watchpoint table checker.
`ifndef BREAKPOINT_WATCHPOINT_TABLE_DEFINES_SVH
`define BREAKPOINT_WATCHPOINT_TABLE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define BWT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent, both sampled on the same clock.
`define BWT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bwt_pkg.sv -----
// Types and constants for the breakpoint and watchpoint match tables.
package bwt_pkg;

    // Default number of entries in each table
    localparam int ENTRIES_DEF = 16;

    // Command codes
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_CHECK  = 2'd3
    } cmd_t;

    // Table selection
    typedef enum logic [1:0] {
        KIND_BREAK = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_BOTH  = 2'd3
    } kind_t;

    // Input item
    typedef struct packed {
        cmd_t        command;
        kind_t       table_kind;
        logic [31:0] address;
    } req_t;

    // Result item
    typedef struct packed {
        logic break_hit;
        logic read_watch_hit;
        logic write_watch_hit;
    } rsp_t;

    // Update operation applied to one table
    typedef struct packed {
        logic insert;
        logic remove;
        logic clear;
    } tbl_op_t;

endpackage

// ----- rtl/core/bwt_table.sv -----
// One address-match table: valid bits, stored addresses and parallel compare.
module bwt_table
    import bwt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  tbl_op_t     op,
    input  logic [31:0] addr,
    output logic        hit
);

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [31:0]        addr_reg [ENTRIES];
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] pick;

    // Per-entry comparators
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (addr_reg[i] == addr);
        end
    end

    assign hit = |match;

    // Lowest free entry as a one-hot vector (zero when full)
    assign pick = ~valid_reg & (valid_reg + ENTRIES'(1));

    // Valid bit update
    always_comb
    begin
        valid_next = valid_reg;
        if (op.clear)
        begin
            valid_next = '0;
        end
        else if (op.remove)
        begin
            valid_next = valid_reg & ~match;
        end
        else if (op.insert)
        begin
            valid_next = valid_reg | pick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Address storage, written only into the picked entry
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (op.insert && pick[i])
            begin
                addr_reg[i] <= addr;
            end
        end
    end

endmodule

// ----- rtl/core/breakpoint_watchpoint_table.sv -----
// The result strobe done passes through the input register and then the result register.
// Throughput: one item per cycle; busy stays low, since parallel comparators and a
// table update in the stage after the input register handle each item.
// Reset: rst_n clears all valid bits and the pipeline strobes; stored addresses are
// not reset and are only compared once written.
// Results cannot be stalled: each is shown for exactly one cycle.
module breakpoint_watchpoint_table
    import bwt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t response
);

    logic    item_valid_reg;
    req_t    item_reg;
    logic    done_reg;
    rsp_t    response_reg;
    rsp_t    response_next;
    tbl_op_t break_op;
    tbl_op_t read_op;
    tbl_op_t write_op;
    logic    break_hit;
    logic    read_hit;
    logic    write_hit;
    logic    sel_break;
    logic    sel_read;
    logic    sel_write;

    // The block never refuses an item
    assign busy = 1'b0;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= request;
        end
    end

    // Decode of table selection
    assign sel_break = (item_reg.table_kind == KIND_BREAK);
    assign sel_read  = (item_reg.table_kind == KIND_READ)  || (item_reg.table_kind == KIND_BOTH);
    assign sel_write = (item_reg.table_kind == KIND_WRITE) || (item_reg.table_kind == KIND_BOTH);

    // Per-table operations; clear of any watch kind empties both watch tables
    always_comb
    begin
        break_op.insert = item_valid_reg && (item_reg.command == CMD_INSERT) && sel_break;
        break_op.remove = item_valid_reg && (item_reg.command == CMD_REMOVE) && sel_break;
        break_op.clear  = item_valid_reg && (item_reg.command == CMD_CLEAR)  && sel_break;
        read_op.insert  = item_valid_reg && (item_reg.command == CMD_INSERT) && sel_read;
        read_op.remove  = item_valid_reg && (item_reg.command == CMD_REMOVE) && sel_read;
        read_op.clear   = item_valid_reg && (item_reg.command == CMD_CLEAR)  && !sel_break;
        write_op.insert = item_valid_reg && (item_reg.command == CMD_INSERT) && sel_write;
        write_op.remove = item_valid_reg && (item_reg.command == CMD_REMOVE) && sel_write;
        write_op.clear  = item_valid_reg && (item_reg.command == CMD_CLEAR)  && !sel_break;
    end

    bwt_table #(.ENTRIES(ENTRIES)) u_break_tbl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (break_op),
        .addr  (item_reg.address),
        .hit   (break_hit)
    );

    bwt_table #(.ENTRIES(ENTRIES)) u_read_tbl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (read_op),
        .addr  (item_reg.address),
        .hit   (read_hit)
    );

    bwt_table #(.ENTRIES(ENTRIES)) u_write_tbl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (write_op),
        .addr  (item_reg.address),
        .hit   (write_hit)
    );

    // Hit flags only for a check, zero otherwise
    always_comb
    begin
        response_next = '0;
        if (item_reg.command == CMD_CHECK)
        begin
            response_next.break_hit       = break_hit;
            response_next.read_watch_hit  = read_hit;
            response_next.write_watch_hit = write_hit;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid_reg)
        begin
            response_reg <= response_next;
        end
    end

    assign done     = done_reg;
    assign response = response_reg;

endmodule

// ----- rtl/core/bwt_checker.sv -----
// Port-level checker for the breakpoint and watchpoint tables, with its bind.
`include "breakpoint_watchpoint_table_defines.svh"

module bwt_checker
    import bwt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t request,
    input logic done,
    input rsp_t response
);

    // Every accepted item produces its result through the input and result registers
    `BWT_ASSERT_IMPLY(a_result_follows, start && !busy, ##2 done, "item without result")

    // No result without a matching accepted item
    `BWT_ASSERT_IMPLY(a_no_spurious, done, $past(start && !busy, 2), "result without item")

    // Only a check can report hits
    `BWT_ASSERT_IMPLY(a_update_no_hit,
        done && $past(start && !busy && (request.command != CMD_CHECK), 2),
        response == '0, "hit flag on an update command")

    // The block takes an item in every cycle
    `BWT_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule

bind breakpoint_watchpoint_table bwt_checker u_bwt_checker (.*);
